// ===== sv/par_pkg.sv =====
// ----------------------------------------------------------------------------
// par_pkg: shared types and constants of the pixel accessibility recolor
// Register indexes, mode codes, the queue item and the control groups that
// pass between the front end, the queue, the back end and the reciprocal unit.
// ----------------------------------------------------------------------------
`default_nettype none

package par_pkg;

  // Configuration register indexes
  localparam int unsigned   CfgIndexW     = 2;
  localparam logic [1:0]    CFG_MODE      = 2'd0;
  localparam logic [1:0]    CFG_THRESHOLD = 2'd1;
  localparam logic [1:0]    CFG_CONTRAST  = 2'd2;

  // Render mode codes (code 3 behaves as pass through)
  localparam logic [1:0]    MODE_PASS     = 2'd0;
  localparam logic [1:0]    MODE_INVERT   = 2'd1;
  localparam logic [1:0]    MODE_GRAY     = 2'd2;

  // Reset values of the configuration registers
  localparam logic [1:0]    ModeReset      = 2'd0;
  localparam logic [7:0]    ThresholdReset = 8'd127;
  localparam logic [7:0]    ContrastReset  = 8'd2;

  // Reciprocal format: floor(2^RecipShift / d), d in 1..255
  localparam int unsigned   RecipShift = 16;
  localparam int unsigned   RecipW     = RecipShift + 1;
  localparam int unsigned   CntW       = $clog2(RecipShift + 1);
  // Numerator of the remap division, at most 128*254
  localparam int unsigned   NumW       = 15;

  // Depth of the queue between front and back
  localparam int unsigned   QueueDepth = 4;

  // Where the gray level sits against the midpoint
  typedef enum logic [1:0] {
    BR_EQUAL = 2'd0,
    BR_ABOVE = 2'd1,
    BR_BELOW = 2'd2
  } branch_t;

  // One classified item on its way to the back end
  typedef struct packed {
    logic        gray;       // 1: build a gray pixel from level
    logic [31:0] pixel;      // finished pixel for pass and invert
    logic        frame_end;
    logic [7:0]  level;      // raw gray level
    branch_t     branch;
  } par_item_t;

  // Reciprocal unit status and results
  typedef struct packed {
    logic              busy;
    logic [RecipW-1:0] rhi;  // for divisor bw_threshold (255 - midpoint)
    logic [RecipW-1:0] rlo;  // for divisor midpoint
  } par_recip_t;

  // Queue status
  typedef struct packed {
    logic full;
    logic empty;
  } par_qstat_t;

endpackage

`default_nettype wire

// ===== sv/par_recip.sv =====
// ----------------------------------------------------------------------------
// par_recip: reciprocal builder
// Restoring division of 2^16 by bw_threshold and then by 255 - bw_threshold,
// one quotient bit per cycle. Starts after reset and after a threshold write.
// ----------------------------------------------------------------------------
`default_nettype none

module par_recip (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                start,
  input  wire logic [7:0]          thr,
  output par_pkg::par_recip_t      recip
);

  localparam logic [par_pkg::CntW-1:0] CntTop = par_pkg::CntW'(par_pkg::RecipShift);

  logic                       busy_r, busy_nxt;
  logic                       phase_r, phase_nxt;
  logic [par_pkg::CntW-1:0]   cnt_r, cnt_nxt;
  logic [7:0]                 rem_r, rem_nxt;
  logic [par_pkg::RecipW-1:0] quo_r, quo_nxt;
  logic [par_pkg::RecipW-1:0] rhi_r, rhi_nxt;
  logic [par_pkg::RecipW-1:0] rlo_r, rlo_nxt;

  logic [7:0]                 divisor;
  logic                       dividend_bit;
  logic [8:0]                 rem_sh;
  logic [7:0]                 rem_sub;
  logic                       ge;
  logic [par_pkg::RecipW-1:0] quo_step;

  // One restoring step; the remainder stays below the divisor
  always_comb begin
    divisor      = phase_r ? (8'd255 - thr) : thr;
    dividend_bit = (cnt_r == CntTop);
    rem_sh       = {rem_r, dividend_bit};
    ge           = (rem_sh >= {1'b0, divisor});
    rem_sub      = ge ? 8'(rem_sh - {1'b0, divisor}) : rem_sh[7:0];
    quo_step     = {quo_r[par_pkg::RecipW-2:0], ge};
  end

  // Sequence both divisions
  always_comb begin
    busy_nxt  = busy_r;
    phase_nxt = phase_r;
    cnt_nxt   = cnt_r;
    rem_nxt   = rem_r;
    quo_nxt   = quo_r;
    rhi_nxt   = rhi_r;
    rlo_nxt   = rlo_r;
    priority if (start) begin
      busy_nxt  = 1'b1;
      phase_nxt = 1'b0;
      cnt_nxt   = CntTop;
      rem_nxt   = '0;
      quo_nxt   = '0;
    end else if (busy_r) begin
      if (cnt_r == '0) begin
        if (!phase_r) begin
          rhi_nxt   = quo_step;
          phase_nxt = 1'b1;
          cnt_nxt   = CntTop;
          rem_nxt   = '0;
          quo_nxt   = '0;
        end else begin
          rlo_nxt  = quo_step;
          busy_nxt = 1'b0;
        end
      end else begin
        cnt_nxt = cnt_r - 1'b1;
        rem_nxt = rem_sub;
        quo_nxt = quo_step;
      end
    end else begin
      // Idle: hold the reciprocals
      busy_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r  <= 1'b1;
      phase_r <= 1'b0;
      cnt_r   <= CntTop;
      rem_r   <= '0;
      quo_r   <= '0;
    end else begin
      busy_r  <= busy_nxt;
      phase_r <= phase_nxt;
      cnt_r   <= cnt_nxt;
      rem_r   <= rem_nxt;
      quo_r   <= quo_nxt;
    end
  end

  // Results hold between rebuilds
  always_ff @(posedge clk) begin
    rhi_r <= rhi_nxt;
    rlo_r <= rlo_nxt;
  end

  assign recip.busy = busy_r;
  assign recip.rhi  = rhi_r;
  assign recip.rlo  = rlo_r;

endmodule

`default_nettype wire

// ===== sv/par_front.sv =====
// ----------------------------------------------------------------------------
// par_front: input stage
// Accepts pixels, finishes pass and invert items, and for gray mode works
// out the gray level and where it lies against the midpoint.
// ----------------------------------------------------------------------------
`default_nettype none

module par_front (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output wire logic               in_ready,
  input  wire logic [31:0]        in_pixel,
  input  wire logic               in_frame_end,
  input  wire logic [1:0]         mode,
  input  wire logic [7:0]         thr,
  input  wire logic               recip_busy,
  input  wire logic               q_full,
  output wire logic               push,
  output par_pkg::par_item_t      push_item
);

  logic                f_valid_r, f_valid_nxt;
  par_pkg::par_item_t  f_item_r, f_item_nxt;

  logic [7:0]  red, grn, blu;
  logic [12:0] luma_sum;
  logic [7:0]  level;
  logic [7:0]  mid;
  logic        accept;

  assign push     = f_valid_r && !q_full;
  assign in_ready = !recip_busy && (!f_valid_r || push);
  assign accept   = in_valid && in_ready;

  // Gray level (11R + 16G + 5B) / 32 by shifts and adds
  always_comb begin
    red      = in_pixel[23:16];
    grn      = in_pixel[15:8];
    blu      = in_pixel[7:0];
    luma_sum = ({5'd0, red} << 3) + ({5'd0, red} << 1) + {5'd0, red}
             + ({5'd0, grn} << 4)
             + ({5'd0, blu} << 2) + {5'd0, blu};
    level    = luma_sum[12:5];
    mid      = 8'd255 - thr;
  end

  // Classify the item
  always_comb begin
    f_item_nxt.pixel     = in_pixel;
    f_item_nxt.frame_end = in_frame_end;
    f_item_nxt.level     = level;
    f_item_nxt.gray      = 1'b0;
    priority if (level > mid) begin
      f_item_nxt.branch = par_pkg::BR_ABOVE;
    end else if (level < mid) begin
      f_item_nxt.branch = par_pkg::BR_BELOW;
    end else begin
      f_item_nxt.branch = par_pkg::BR_EQUAL;
    end
    unique case (mode)
      par_pkg::MODE_INVERT: f_item_nxt.pixel = in_pixel ^ 32'h00FF_FFFF;
      par_pkg::MODE_GRAY:   f_item_nxt.gray  = 1'b1;
      default:              f_item_nxt.pixel = in_pixel;
    endcase
  end

  // Hold the item until the queue takes it
  always_comb begin
    f_valid_nxt = f_valid_r;
    priority if (accept) begin
      f_valid_nxt = 1'b1;
    end else if (push) begin
      f_valid_nxt = 1'b0;
    end else begin
      f_valid_nxt = f_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      f_valid_r <= 1'b0;
    end else begin
      f_valid_r <= f_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      f_item_r <= f_item_nxt;
    end
  end

  assign push_item = f_item_r;

endmodule

`default_nettype wire

// ===== sv/par_queue.sv =====
// ----------------------------------------------------------------------------
// par_queue: item queue between front and back
// Small register FIFO; lets either side stall without stopping the other.
// ----------------------------------------------------------------------------
`default_nettype none

module par_queue (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  push,
  input  wire par_pkg::par_item_t    push_item,
  input  wire logic                  pop,
  output par_pkg::par_item_t         head,
  output par_pkg::par_qstat_t        stat
);

  localparam int unsigned Depth = par_pkg::QueueDepth;
  localparam int unsigned PtrW  = $clog2(Depth);
  localparam int unsigned CntQW = $clog2(Depth + 1);

  par_pkg::par_item_t  mem_r [Depth];
  logic [PtrW-1:0]     wr_ptr_r, wr_ptr_nxt;
  logic [PtrW-1:0]     rd_ptr_r, rd_ptr_nxt;
  logic [CntQW-1:0]    count_r, count_nxt;
  logic                do_push, do_pop;

  assign stat.full  = (count_r == CntQW'(Depth));
  assign stat.empty = (count_r == '0);
  assign do_push    = push && !stat.full;
  assign do_pop     = pop && !stat.empty;
  assign head       = mem_r[rd_ptr_r];

  // Advance pointers and fill count
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PtrW'(Depth - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PtrW'(Depth - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    unique case ({do_push, do_pop})
      2'b10:   count_nxt = count_r + 1'b1;
      2'b01:   count_nxt = count_r - 1'b1;
      default: count_nxt = count_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_item;
    end
  end

endmodule

`default_nettype wire

// ===== sv/par_back.sv =====
// ----------------------------------------------------------------------------
// par_back: remap pipeline and output register
// Divides by the midpoint terms through stored reciprocals with one
// correction step, applies the contrast stretch and clamp, builds the pixel.
// ----------------------------------------------------------------------------
`default_nettype none

module par_back (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire par_pkg::par_item_t    head,
  input  wire par_pkg::par_qstat_t   qstat,
  output wire logic                  pop,
  input  wire logic [7:0]            thr,
  input  wire logic [7:0]            con,
  input  wire par_pkg::par_recip_t   recip,
  output wire logic                  out_valid,
  input  wire logic                  out_ready,
  output wire logic [31:0]           out_pixel,
  output wire logic                  out_frame_end
);

  localparam int unsigned RW = par_pkg::RecipW;
  localparam int unsigned NW = par_pkg::NumW;
  localparam int unsigned PW = NW + RW;

  logic       advance;
  logic [7:0] mid;

  // Stage registers
  logic                s1_valid_r, s2_valid_r, s3_valid_r, s4_valid_r, s5_valid_r;
  par_pkg::par_item_t  s1_item_r, s2_item_r, s3_item_r, s4_item_r, s5_item_r;
  logic [NW-1:0]       s1_num_r, s2_num_r, s3_num_r;
  logic [RW-1:0]       s1_rcp_r;
  logic [7:0]          s1_div_r, s2_div_r, s3_div_r;
  logic [PW-1:0]       s2_prod_r;
  logic [7:0]          s3_q0_r;
  logic [15:0]         s3_qd_r;
  logic [7:0]          s4_level_r, s5_level_r;
  logic signed [17:0]  s5_prod_r;

  logic                out_valid_r, out_valid_nxt;
  logic [31:0]         out_pixel_r, out_pixel_nxt;
  logic                out_frame_end_r;

  // Stage 1 terms
  logic [7:0]          diff_hi;
  logic [NW-1:0]       num_hi, num_lo, s1_num_nxt;
  logic [RW-1:0]       s1_rcp_nxt;
  logic [7:0]          s1_div_nxt;
  // Stage 4 terms
  logic [15:0]         rem;
  logic [7:0]          q_fix;
  logic [7:0]          s4_level_nxt;
  // Stage 5 terms
  logic signed [9:0]   lvl_diff;
  logic signed [19:0]  con_prod;
  // Output stage terms
  logic signed [17:0]  prod_adj;
  logic signed [17:0]  half;
  logic signed [18:0]  stretched;
  logic [7:0]          final_level;

  assign mid     = 8'd255 - thr;
  assign advance = !out_valid_r || out_ready;
  assign pop     = advance && !qstat.empty;

  // Pick numerator, reciprocal and divisor by branch
  always_comb begin
    diff_hi = head.level - mid;
    num_hi  = ({7'd0, diff_hi} << 7) - {7'd0, diff_hi};
    num_lo  = {head.level, 7'd0};
    unique case (head.branch)
      par_pkg::BR_ABOVE: begin
        s1_num_nxt = num_hi;
        s1_rcp_nxt = recip.rhi;
        s1_div_nxt = thr;
      end
      par_pkg::BR_BELOW: begin
        s1_num_nxt = num_lo;
        s1_rcp_nxt = recip.rlo;
        s1_div_nxt = mid;
      end
      default: begin
        s1_num_nxt = '0;
        s1_rcp_nxt = '0;
        s1_div_nxt = '0;
      end
    endcase
  end

  // Correct the estimated quotient and place it around the midpoint
  always_comb begin
    rem   = {1'b0, s3_num_r} - s3_qd_r;
    q_fix = s3_q0_r + ((rem >= {8'd0, s3_div_r}) ? 8'd1 : 8'd0);
    unique case (s3_item_r.branch)
      par_pkg::BR_ABOVE: s4_level_nxt = 8'd128 + q_fix;
      par_pkg::BR_BELOW: s4_level_nxt = q_fix;
      default:           s4_level_nxt = s3_item_r.level;
    endcase
  end

  // Contrast product
  always_comb begin
    lvl_diff = $signed({2'b00, s4_level_r}) - $signed({2'b00, mid});
    con_prod = $signed({2'b00, con}) * lvl_diff;
  end

  // Halve toward zero, recenter, clamp, build the pixel
  always_comb begin
    prod_adj  = s5_prod_r + $signed({17'd0, s5_prod_r[17]});
    half      = prod_adj >>> 1;
    stretched = $signed({half[17], half}) + $signed({11'd0, mid});
    priority if (con <= 8'd2) begin
      final_level = s5_level_r;
    end else if (stretched < 0) begin
      final_level = 8'd0;
    end else if (stretched > 19'sd255) begin
      final_level = 8'd255;
    end else begin
      final_level = stretched[7:0];
    end
    out_pixel_nxt = s5_item_r.gray
                  ? {8'hFF, final_level, final_level, final_level}
                  : s5_item_r.pixel;
    out_valid_nxt = advance ? s5_valid_r : out_valid_r;
  end

  // Valid bits shift on advance
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      s2_valid_r  <= 1'b0;
      s3_valid_r  <= 1'b0;
      s4_valid_r  <= 1'b0;
      s5_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (advance) begin
        s1_valid_r <= !qstat.empty;
        s2_valid_r <= s1_valid_r;
        s3_valid_r <= s2_valid_r;
        s4_valid_r <= s3_valid_r;
        s5_valid_r <= s4_valid_r;
      end
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload moves with the valid bits
  always_ff @(posedge clk) begin
    if (advance) begin
      s1_item_r       <= head;
      s1_num_r        <= s1_num_nxt;
      s1_rcp_r        <= s1_rcp_nxt;
      s1_div_r        <= s1_div_nxt;

      s2_item_r       <= s1_item_r;
      s2_num_r        <= s1_num_r;
      s2_div_r        <= s1_div_r;
      s2_prod_r       <= {{RW{1'b0}}, s1_num_r} * {{NW{1'b0}}, s1_rcp_r};

      s3_item_r       <= s2_item_r;
      s3_num_r        <= s2_num_r;
      s3_div_r        <= s2_div_r;
      s3_q0_r         <= s2_prod_r[par_pkg::RecipShift +: 8];
      s3_qd_r         <= {8'd0, s2_prod_r[par_pkg::RecipShift +: 8]} * {8'd0, s2_div_r};

      s4_item_r       <= s3_item_r;
      s4_level_r      <= s4_level_nxt;

      s5_item_r       <= s4_item_r;
      s5_level_r      <= s4_level_r;
      s5_prod_r       <= con_prod[17:0];

      out_pixel_r     <= out_pixel_nxt;
      out_frame_end_r <= s5_item_r.frame_end;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_pixel     = out_pixel_r;
  assign out_frame_end = out_frame_end_r;

endmodule

`default_nettype wire

// ===== sv/pixel_accessibility_recolor.sv =====
// ----------------------------------------------------------------------------
// pixel_accessibility_recolor: accessibility recolor of an ARGB pixel stream
// Pass through, color inversion, or gray level with threshold remap and
// contrast stretch, selected by configuration registers.
// ----------------------------------------------------------------------------
// Throughput: one pixel per clock through the remap pipeline, while
// out_ready is high and no reciprocal rebuild runs.
// Reset: registers take mode 0, threshold 127, contrast 2; then the
// reciprocal unit rebuilds its two reciprocals, with in_ready low. A
// threshold write starts the same rebuild.
// ----------------------------------------------------------------------------
`default_nettype none

module pixel_accessibility_recolor (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  // configuration writes
  input  wire logic                            cfg_valid,
  output wire logic                            cfg_ready,
  input  wire logic [par_pkg::CfgIndexW-1:0]   cfg_index,
  input  wire logic [7:0]                      cfg_data,
  // input pixels
  input  wire logic                            in_valid,
  output wire logic                            in_ready,
  input  wire logic [31:0]                     in_pixel,
  input  wire logic                            in_frame_end,
  // result pixels
  output wire logic                            out_valid,
  input  wire logic                            out_ready,
  output wire logic [31:0]                     out_pixel,
  output wire logic                            out_frame_end
);

  logic [1:0] mode_r, mode_nxt;
  logic [7:0] thr_r, thr_nxt;
  logic [7:0] con_r, con_nxt;
  logic       cfg_write;
  logic       thr_write;

  par_pkg::par_recip_t  recip;
  par_pkg::par_qstat_t  qstat;
  par_pkg::par_item_t   push_item;
  par_pkg::par_item_t   head;
  logic                 push;
  logic                 pop;

  assign cfg_ready = 1'b1;
  assign cfg_write = cfg_valid && cfg_ready;
  assign thr_write = cfg_write && (cfg_index == par_pkg::CFG_THRESHOLD);

  // Decode register writes; unknown indexes are dropped
  always_comb begin
    mode_nxt = mode_r;
    thr_nxt  = thr_r;
    con_nxt  = con_r;
    if (cfg_write) begin
      unique case (cfg_index)
        par_pkg::CFG_MODE:      mode_nxt = cfg_data[1:0];
        par_pkg::CFG_THRESHOLD: thr_nxt  = cfg_data;
        par_pkg::CFG_CONTRAST:  con_nxt  = cfg_data;
        default: begin
          mode_nxt = mode_r;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= par_pkg::ModeReset;
      thr_r  <= par_pkg::ThresholdReset;
      con_r  <= par_pkg::ContrastReset;
    end else begin
      mode_r <= mode_nxt;
      thr_r  <= thr_nxt;
      con_r  <= con_nxt;
    end
  end

  par_recip u_recip (
    .clk   (clk),
    .rst_n (rst_n),
    .start (thr_write),
    .thr   (thr_r),
    .recip (recip)
  );

  par_front u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_pixel     (in_pixel),
    .in_frame_end (in_frame_end),
    .mode         (mode_r),
    .thr          (thr_r),
    .recip_busy   (recip.busy),
    .q_full       (qstat.full),
    .push         (push),
    .push_item    (push_item)
  );

  par_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_item (push_item),
    .pop       (pop),
    .head      (head),
    .stat      (qstat)
  );

  par_back u_back (
    .clk           (clk),
    .rst_n         (rst_n),
    .head          (head),
    .qstat         (qstat),
    .pop           (pop),
    .thr           (thr_r),
    .con           (con_r),
    .recip         (recip),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_pixel     (out_pixel),
    .out_frame_end (out_frame_end)
  );

  // No pixel enters while the reciprocals are being rebuilt
  a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |-> !recip.busy)
    else $error("pixel accepted during reciprocal rebuild");

  // Reset starts a reciprocal rebuild
  a_reset_rebuild: assert property (@(posedge clk)
    !rst_n |=> recip.busy)
    else $error("reciprocal rebuild not started by reset");

  // A rebuild runs its full two divisions before finishing
  a_rebuild_length: assert property (@(posedge clk) disable iff (!rst_n)
    $fell(recip.busy) |-> $past(recip.busy, 33))
    else $error("reciprocal rebuild ended early");

endmodule

`default_nettype wire

// ===== bench/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for the pixel accessibility recolor
// A table of directed pixels covers reset values, every mode, the midpoint
// extremes and contrast clamping. Random phases with fresh register settings
// follow. Every result is compared with a typed result or a behavioral recolor.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [1:0] MODE_UNUSED  = 2'd3;
  localparam logic [1:0] CFG_UNUSED   = 2'd3;
  localparam int         IdlePct      = 22;
  localparam int         HoldCycles   = 150;
  localparam int         SettleCycles = 12;
  localparam int         NumPhases    = 10;
  localparam int         PhaseItems   = 125;
  localparam int         CycleLimit   = 400000;

  typedef struct packed {
    logic [31:0] pixel;
    logic        frame_end;
  } px_result_t;

  typedef struct packed {
    logic [1:0]  mode;
    logic [7:0]  thr;
    logic [7:0]  con;
    logic [31:0] pixel;
    logic        frame_end;
    logic        known;   // 1: want holds the result
    logic [31:0] want;
  } dir_row_t;

  // Directed pixels; rows without a typed result use the recolor function
  localparam int NumRows = 24;
  dir_row_t dir_rows [NumRows] = '{
    '{par_pkg::MODE_PASS,   8'd127, 8'd2,   32'h12345678, 1'b0, 1'b1, 32'h12345678},
    '{par_pkg::MODE_PASS,   8'd127, 8'd2,   32'hFFFFFFFF, 1'b1, 1'b1, 32'hFFFFFFFF},
    '{par_pkg::MODE_PASS,   8'd127, 8'd2,   32'h00000000, 1'b0, 1'b1, 32'h00000000},
    '{par_pkg::MODE_INVERT, 8'd127, 8'd2,   32'h00000000, 1'b0, 1'b1, 32'h00FFFFFF},
    '{par_pkg::MODE_INVERT, 8'd127, 8'd2,   32'hFFFFFFFF, 1'b1, 1'b1, 32'hFF000000},
    '{par_pkg::MODE_INVERT, 8'd127, 8'd2,   32'h80A5C3F0, 1'b0, 1'b1, 32'h805A3C0F},
    '{MODE_UNUSED,          8'd127, 8'd2,   32'hDEADBEEF, 1'b0, 1'b1, 32'hDEADBEEF},
    '{par_pkg::MODE_GRAY,   8'd127, 8'd2,   32'h00000000, 1'b0, 1'b1, 32'hFF000000},
    '{par_pkg::MODE_GRAY,   8'd127, 8'd2,   32'h00FFFFFF, 1'b1, 1'b1, 32'hFFFFFFFF},
    '{par_pkg::MODE_GRAY,   8'd127, 8'd2,   32'h12808080, 1'b0, 1'b1, 32'hFF808080},
    '{par_pkg::MODE_GRAY,   8'd127, 8'd2,   32'h7F3A9C51, 1'b0, 1'b0, 32'h0},
    '{par_pkg::MODE_GRAY,   8'd0,   8'd2,   32'h00FFFFFF, 1'b0, 1'b1, 32'hFFFFFFFF},
    '{par_pkg::MODE_GRAY,   8'd0,   8'd2,   32'h00102030, 1'b0, 1'b0, 32'h0},
    '{par_pkg::MODE_GRAY,   8'd255, 8'd2,   32'h00000000, 1'b0, 1'b1, 32'hFF000000},
    '{par_pkg::MODE_GRAY,   8'd255, 8'd2,   32'h00FFFFFF, 1'b0, 1'b1, 32'hFFFFFFFF},
    '{par_pkg::MODE_GRAY,   8'd255, 8'd2,   32'h00405060, 1'b1, 1'b0, 32'h0},
    '{par_pkg::MODE_GRAY,   8'd127, 8'd255, 32'h00000000, 1'b0, 1'b1, 32'hFF000000},
    '{par_pkg::MODE_GRAY,   8'd127, 8'd255, 32'h00FFFFFF, 1'b0, 1'b1, 32'hFFFFFFFF},
    '{par_pkg::MODE_GRAY,   8'd127, 8'd255, 32'h00808080, 1'b0, 1'b1, 32'hFF808080},
    '{par_pkg::MODE_GRAY,   8'd127, 8'd255, 32'h00817F80, 1'b0, 1'b0, 32'h0},
    '{par_pkg::MODE_GRAY,   8'd200, 8'd3,   32'h00303030, 1'b0, 1'b0, 32'h0},
    '{par_pkg::MODE_GRAY,   8'd200, 8'd3,   32'hF0F0E0D0, 1'b1, 1'b0, 32'h0},
    '{par_pkg::MODE_INVERT, 8'd200, 8'd3,   32'hA5A5A5A5, 1'b0, 1'b1, 32'hA55A5A5A},
    '{par_pkg::MODE_GRAY,   8'd127, 8'd0,   32'hFF336699, 1'b0, 1'b0, 32'h0}
  };

  logic        clk;
  logic        rst_n;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [1:0]  cfg_index;
  logic [7:0]  cfg_data;
  logic        in_valid;
  logic        in_ready;
  logic [31:0] in_pixel;
  logic        in_frame_end;
  logic        out_valid;
  logic        out_ready;
  logic [31:0] out_pixel;
  logic        out_frame_end;

  // Register copies as last written
  logic [1:0]  mode_q;
  logic [7:0]  thr_q;
  logic [7:0]  con_q;

  px_result_t  pending_pixels[$];
  int          errors;
  int          cycles;
  bit          no_idle;
  bit          hold_req;

  pixel_accessibility_recolor DUT (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_pixel      (in_pixel),
    .in_frame_end  (in_frame_end),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_pixel     (out_pixel),
    .out_frame_end (out_frame_end)
  );

  // Recolor one pixel under the current register copies
  function automatic logic [31:0] recolor_pixel(input logic [31:0] px);
    int r, g, b, mid, con, lvl;
    logic [7:0] u;
    r   = px[23:16];
    g   = px[15:8];
    b   = px[7:0];
    mid = 255 - int'(thr_q);
    con = con_q;
    if (mode_q == par_pkg::MODE_INVERT) begin
      return px ^ 32'h00FFFFFF;
    end
    if (mode_q != par_pkg::MODE_GRAY) begin
      return px;
    end
    lvl = (11 * r + 16 * g + 5 * b) / 32;
    if (lvl > mid) begin
      lvl = 128 + (127 * (lvl - mid)) / (255 - mid);
    end else if (lvl < mid) begin
      lvl = (128 * lvl) / mid;
    end
    if (con > 2) begin
      lvl = (con * (lvl - mid)) / 2 + mid;
      if (lvl > 255) begin
        lvl = 255;
      end else if (lvl < 0) begin
        lvl = 0;
      end
    end
    u = lvl[7:0];
    return {8'hFF, u, u, u};
  endfunction

  // Pick a random pixel, often a gray one at or next to the midpoint
  function automatic logic [31:0] pick_pixel();
    int c;
    if ($urandom_range(3) == 0) begin
      c = 255 - int'(thr_q) + int'($urandom_range(2)) - 1;
      if (c < 0) begin
        c = 0;
      end else if (c > 255) begin
        c = 255;
      end
      return {8'($urandom), 8'(c), 8'(c), 8'(c)};
    end
    return $urandom;
  endfunction

  // Clock
  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Bound the run
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("pixel_accessibility_recolor: mismatch");
      $finish;
    end
  end

  // Drive out_ready: random stalls, one long hold-off, a quiet stretch
  initial begin
    int hold_left;
    hold_left = 0;
    out_ready = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        hold_req  = 1'b0;
        hold_left = HoldCycles;
      end
      if (hold_left > 0) begin
        out_ready <= 1'b0;
        hold_left--;
      end else if (no_idle) begin
        out_ready <= 1'b1;
      end else begin
        out_ready <= ($urandom_range(99) >= IdlePct);
      end
    end
  end

  // Check each accepted result against the oldest prediction
  always @(negedge clk) begin
    px_result_t want;
    if (rst_n && out_valid && out_ready) begin
      if (pending_pixels.size() == 0) begin
        errors++;
        $display("%0t: unexpected item: expected none, actual pixel %h frame_end %b",
                 $realtime, out_pixel, out_frame_end);
      end else begin
        want = pending_pixels.pop_front();
        if (out_pixel !== want.pixel) begin
          errors++;
          $display("%0t: pixel: expected %h, actual %h", $realtime, want.pixel, out_pixel);
        end
        if (out_frame_end !== want.frame_end) begin
          errors++;
          $display("%0t: frame_end: expected %b, actual %b",
                   $realtime, want.frame_end, out_frame_end);
        end
      end
    end
  end

  // Offer one pixel; idle at random first, hold valid and payload until accepted
  task automatic send_pixel(input logic [31:0] px, input logic fe, input logic [31:0] want);
    while (!no_idle && $urandom_range(99) < IdlePct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid     <= 1'b1;
    in_pixel     <= px;
    in_frame_end <= fe;
    do @(negedge clk); while (!in_ready);
    pending_pixels.push_back('{pixel: want, frame_end: fe});
    @(posedge clk);
  endtask

  // Write one register; leave valid high unless this is the last write
  task automatic write_reg(input logic [1:0] idx, input logic [7:0] data, input bit last);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(negedge clk); while (!cfg_ready);
    @(posedge clk);
    unique case (idx)
      par_pkg::CFG_MODE:      mode_q = data[1:0];
      par_pkg::CFG_THRESHOLD: thr_q  = data;
      par_pkg::CFG_CONTRAST:  con_q  = data;
      default: ;
    endcase
    if (last) begin
      cfg_valid <= 1'b0;
    end
  endtask

  // Stop offering, then wait until every prediction has been met
  task automatic drain();
    in_valid <= 1'b0;
    while (pending_pixels.size() != 0) @(posedge clk);
    repeat (SettleCycles) @(posedge clk);
  endtask

  task automatic program_regs(input logic [7:0] mode_data, input logic [7:0] thr,
                              input logic [7:0] con);
    write_reg(par_pkg::CFG_MODE, mode_data, 1'b0);
    write_reg(par_pkg::CFG_THRESHOLD, thr, 1'b0);
    write_reg(par_pkg::CFG_CONTRAST, con, 1'b1);
  endtask

  // Stimulus
  initial begin
    logic [1:0]  mode;
    logic [7:0]  thr;
    logic [7:0]  con;
    logic [31:0] px;
    logic        fe;
    errors       = 0;
    cycles       = 0;
    no_idle      = 1'b0;
    hold_req     = 1'b0;
    rst_n        = 1'b0;
    cfg_valid    = 1'b0;
    cfg_index    = par_pkg::CFG_MODE;
    cfg_data     = 8'h00;
    in_valid     = 1'b0;
    in_pixel     = 32'h0;
    in_frame_end = 1'b0;
    mode_q       = par_pkg::ModeReset;
    thr_q        = par_pkg::ThresholdReset;
    con_q        = par_pkg::ContrastReset;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed table; reprogram whenever a row asks for other settings
    for (int i = 0; i < NumRows; i++) begin
      if (dir_rows[i].mode != mode_q || dir_rows[i].thr != thr_q ||
          dir_rows[i].con != con_q) begin
        drain();
        program_regs({6'($urandom), dir_rows[i].mode}, dir_rows[i].thr, dir_rows[i].con);
      end
      send_pixel(dir_rows[i].pixel, dir_rows[i].frame_end,
                 dir_rows[i].known ? dir_rows[i].want : recolor_pixel(dir_rows[i].pixel));
    end

    // Random phases, each with fresh settings
    for (int ph = 0; ph < NumPhases; ph++) begin
      drain();
      if (ph == 0) begin
        write_reg(CFG_UNUSED, 8'($urandom), 1'b0);
      end
      case ($urandom_range(9))
        0:       mode = par_pkg::MODE_PASS;
        1:       mode = par_pkg::MODE_INVERT;
        2:       mode = MODE_UNUSED;
        default: mode = par_pkg::MODE_GRAY;
      endcase
      case ($urandom_range(5))
        0:       thr = 8'd0;
        1:       thr = 8'd255;
        2:       thr = par_pkg::ThresholdReset;
        default: thr = 8'($urandom);
      endcase
      case ($urandom_range(6))
        0:       con = 8'd0;
        1:       con = 8'd2;
        2:       con = 8'd3;
        3:       con = 8'd255;
        default: con = 8'($urandom);
      endcase
      program_regs({6'($urandom), mode}, thr, con);
      no_idle = (ph == 5);
      if (ph == 2) begin
        hold_req = 1'b1;
      end
      for (int n = 0; n < PhaseItems; n++) begin
        px = pick_pixel();
        fe = ($urandom_range(7) == 0);
        send_pixel(px, fe, recolor_pixel(px));
      end
    end

    // Wait out the last results, then report
    drain();
    if (errors == 0 && pending_pixels.size() == 0) begin
      $display("pixel_accessibility_recolor: match");
    end else begin
      $display("pixel_accessibility_recolor: mismatch");
    end
    $finish;
  end

endmodule

`default_nettype wire

// ===== files.f =====
sv/par_pkg.sv
sv/par_recip.sv
sv/par_front.sv
sv/par_queue.sv
sv/par_back.sv
sv/pixel_accessibility_recolor.sv
bench/tb_top.sv
